// ----- src/irpp_pkg.sv -----
// ----------------------------------------------------------------------------
// irpp_pkg
// Shared widths, byte codes and register indexes for the infrared raw byte
// to pulse/space decoder.
// ----------------------------------------------------------------------------
package irpp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned DurW   = 24;
  localparam int unsigned TickW  = 8;
  localparam int unsigned CountW = 5;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 24;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TICK_UNIT     = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_SPACE = 1'd1;

  localparam logic [TickW-1:0] TICK_UNIT_RST     = 8'd50;
  localparam logic [DurW-1:0]  TIMEOUT_SPACE_RST = 24'd100000;
  localparam logic [DurW-1:0]  SPACE_ACCUM_RST   = 24'hFF_FFFF;

  // byte codes
  localparam logic [ByteW-1:0] HDR_LO      = 8'h81;
  localparam logic [ByteW-1:0] HDR_HI      = 8'h9E;
  localparam logic [ByteW-1:0] TIMEOUT_MRK = 8'h9F;
  localparam logic [CountW-1:0] SKIP_COUNT = 5'd7;

endpackage

// ----- src/irpp_byte_if.sv -----
// ----------------------------------------------------------------------------
// irpp_byte_if
// Valid/ready channel carrying one raw received byte.
// ----------------------------------------------------------------------------
interface irpp_byte_if;
  logic                        valid;
  logic                        ready;
  logic [irpp_pkg::ByteW-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- src/irpp_pulse_if.sv -----
// ----------------------------------------------------------------------------
// irpp_pulse_if
// Valid/ready channel carrying one pulse or space result.
// ----------------------------------------------------------------------------
interface irpp_pulse_if;
  logic                       valid;
  logic                       ready;
  logic [irpp_pkg::DurW-1:0]  duration;
  logic                       is_pulse;
  logic                       last;

  modport source (output valid, output duration, output is_pulse, output last, input ready);
  modport sink   (input valid, input duration, input is_pulse, input last, output ready);
endinterface

// ----- src/ir_raw_packet_to_pulse_space.sv -----
// ----------------------------------------------------------------------------
// ir_raw_packet_to_pulse_space
// Decodes the raw byte stream of an infrared receiver into pulse and space
// durations in microseconds.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   takes one received byte per transfer.
//   out_ch  gives pulse/space results; a pulse byte inside a packet gives two
//           transfers, the accumulated space (last=0) then the pulse (last=1).
//   cfg_*   writes tick_unit (index 0) or timeout_space (index 1); write only
//           while the block is idle.
// Path: a byte's count is multiplied by tick_unit as it enters the input
//   register; its first result is then loaded into the output register, from
//   which out_ch can take it.
// Throughput: one byte per cycle while no pulse byte waits for room; a pulse
//   byte waits until the output register and the pending slot are both free,
//   as the single output register plus one pending slot drain one result a cycle.
// Reset: parser idle, space accumulator all ones, registers at 50 and 100000,
//   both channels empty.
// Stall: when out_ch is not ready, results hold; space and header bytes still
//   pass until a pulse byte waits in the input register, then in_ch.ready falls.
// ----------------------------------------------------------------------------
module ir_raw_packet_to_pulse_space (
  input  logic                                clk,
  input  logic                                rst_n,
  irpp_byte_if.sink                           in_ch,
  irpp_pulse_if.source                        out_ch,
  input  logic                                cfg_we,
  input  logic [irpp_pkg::CfgIdxW-1:0]        cfg_idx,
  input  logic [irpp_pkg::CfgDataW-1:0]       cfg_wdata
);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_PACKET = 2'd1,
    MODE_SKIP   = 2'd2
  } mode_t;

  // configuration
  logic [irpp_pkg::TickW-1:0]  tick_r;
  logic [irpp_pkg::DurW-1:0]   timeout_r;

  // input register
  logic                        in_vld_r;
  logic [irpp_pkg::ByteW-1:0]  in_byte_r;
  logic [irpp_pkg::DurW-1:0]   in_dur_r;

  // parser state
  mode_t                       mode_r, mode_nxt;
  logic [irpp_pkg::CountW-1:0] left_r, left_nxt;
  logic [irpp_pkg::DurW-1:0]   space_r, space_nxt;

  // result register and pending pulse slot
  logic                        out_vld_r;
  logic [irpp_pkg::DurW-1:0]   out_dur_r;
  logic                        out_pulse_r;
  logic                        out_last_r;
  logic                        pend_vld_r;
  logic [irpp_pkg::DurW-1:0]   pend_dur_r;

  logic in_fire, proc_fire, emits, out_free, room;

  assign out_free  = !out_vld_r || out_ch.ready;
  assign room      = out_free && !pend_vld_r;
  assign emits     = (mode_r == MODE_PACKET) && in_byte_r[7];
  assign proc_fire = in_vld_r && (!emits || room);
  assign in_ch.ready = !in_vld_r || proc_fire;
  assign in_fire   = in_ch.valid && in_ch.ready;

  assign out_ch.valid    = out_vld_r;
  assign out_ch.duration = out_dur_r;
  assign out_ch.is_pulse = out_pulse_r;
  assign out_ch.last     = out_last_r;

  always_comb begin
    mode_nxt  = mode_r;
    left_nxt  = left_r;
    space_nxt = space_r;
    case (mode_r)
      MODE_PACKET: begin
        if (in_byte_r[7]) begin
          space_nxt = '0;
        end else begin
          space_nxt = space_r + in_dur_r;
        end
        left_nxt = left_r - 1'b1;
        if (left_nxt == '0) begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_SKIP: begin
        left_nxt = left_r - 1'b1;
        if (left_nxt == '0) begin
          mode_nxt = MODE_IDLE;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
        if (in_byte_r inside {[irpp_pkg::HDR_LO:irpp_pkg::HDR_HI]}) begin
          left_nxt = in_byte_r[irpp_pkg::CountW-1:0];
          mode_nxt = MODE_PACKET;
        end else if (in_byte_r == irpp_pkg::TIMEOUT_MRK) begin
          space_nxt = space_r + timeout_r;
          left_nxt  = irpp_pkg::SKIP_COUNT;
          mode_nxt  = MODE_SKIP;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r     <= irpp_pkg::TICK_UNIT_RST;
      timeout_r  <= irpp_pkg::TIMEOUT_SPACE_RST;
      in_vld_r   <= 1'b0;
      mode_r     <= MODE_IDLE;
      left_r     <= '0;
      space_r    <= irpp_pkg::SPACE_ACCUM_RST;
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          irpp_pkg::CFG_TICK_UNIT:     tick_r    <= cfg_wdata[irpp_pkg::TickW-1:0];
          irpp_pkg::CFG_TIMEOUT_SPACE: timeout_r <= cfg_wdata[irpp_pkg::DurW-1:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        in_vld_r <= 1'b1;
      end else if (proc_fire) begin
        in_vld_r <= 1'b0;
      end

      if (proc_fire) begin
        mode_r  <= mode_nxt;
        left_r  <= left_nxt;
        space_r <= space_nxt;
      end

      // pending pulse moves up first; a new pulse byte needs both slots free
      if (out_free) begin
        if (pend_vld_r) begin
          out_vld_r   <= 1'b1;
          out_dur_r   <= pend_dur_r;
          out_pulse_r <= 1'b1;
          out_last_r  <= 1'b1;
          pend_vld_r  <= 1'b0;
        end else if (proc_fire && emits) begin
          out_vld_r   <= 1'b1;
          out_dur_r   <= space_r;
          out_pulse_r <= 1'b0;
          out_last_r  <= 1'b0;
          pend_vld_r  <= 1'b1;
          pend_dur_r  <= in_dur_r;
        end else begin
          out_vld_r   <= 1'b0;
        end
      end
    end
  end

  // duration product is registered with the byte
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_ch.rx_byte;
      in_dur_r  <= irpp_pkg::DurW'(in_ch.rx_byte[6:0]) * irpp_pkg::DurW'(tick_r);
    end
  end

  // a pending pulse always sits behind its space result
  a_pend_behind_space: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (out_vld_r && !out_pulse_r && !out_last_r))
    else $error("pending pulse without its space result ahead");

  // idle parser has no bytes outstanding, busy parser has some
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) == (left_r == '0))
    else $error("byte count out of step with parse mode");

  // a pulse byte never leaves while both result slots are not free
  a_pulse_room: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && emits) |=> (pend_vld_r && out_vld_r))
    else $error("pulse byte processed without result room");

  // the accumulator is cleared once a pulse byte is taken
  a_space_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && emits) |=> (space_r == '0))
    else $error("space accumulator not cleared after pulse");

endmodule

// ----- dv/ir_raw_packet_to_pulse_space_tb.sv -----
// ----------------------------------------------------------------------------
// ir_raw_packet_to_pulse_space_tb
// Self-checking bench for the infrared raw byte decoder. A short directed
// table (ignored bytes, wrap of the space total, timeout marker and skip,
// code-like data bytes) is followed by random packet traffic over several
// register settings and idle patterns. The results are checked against an
// in-bench decoder, in order and field by field.
// ----------------------------------------------------------------------------
module ir_raw_packet_to_pulse_space_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 150;

  typedef enum logic [1:0] {PM_IDLE, PM_PACKET, PM_SKIP} parse_mode_t;

  typedef struct packed {
    logic [irpp_pkg::DurW-1:0] duration;
    logic                      is_pulse;
    logic                      last;
  } pulse_space_t;

  typedef struct packed {
    logic [irpp_pkg::ByteW-1:0] rx;
    logic                       typed;     // space/pulse pair written out below
    logic [irpp_pkg::DurW-1:0]  space_us;
    logic [irpp_pkg::DurW-1:0]  pulse_us;
  } stim_row_t;

  // rows assume the reset register values
  localparam stim_row_t DIRECTED [22] = '{
    '{8'h00, 1'b0, 24'd0, 24'd0},                // ignored while idle
    '{8'hFF, 1'b0, 24'd0, 24'd0},
    '{8'h80, 1'b0, 24'd0, 24'd0},                // just below the header range
    '{8'hA0, 1'b0, 24'd0, 24'd0},
    '{irpp_pkg::HDR_LO + 8'd1, 1'b0, 24'd0, 24'd0},   // two data bytes
    '{8'h01, 1'b0, 24'd0, 24'd0},                // all-ones total wraps to 49
    '{8'h80, 1'b1, 24'd49, 24'd0},               // zero-length pulse
    '{irpp_pkg::TIMEOUT_MRK, 1'b0, 24'd0, 24'd0},
    '{irpp_pkg::HDR_LO, 1'b0, 24'd0, 24'd0},     // seven skipped bytes
    '{irpp_pkg::TIMEOUT_MRK, 1'b0, 24'd0, 24'd0},
    '{8'hFF, 1'b0, 24'd0, 24'd0},
    '{8'h00, 1'b0, 24'd0, 24'd0},
    '{8'h80, 1'b0, 24'd0, 24'd0},
    '{irpp_pkg::HDR_HI, 1'b0, 24'd0, 24'd0},
    '{8'h7F, 1'b0, 24'd0, 24'd0},
    '{irpp_pkg::HDR_LO + 8'd2, 1'b0, 24'd0, 24'd0},   // three data bytes
    '{8'h7F, 1'b0, 24'd0, 24'd0},
    '{irpp_pkg::TIMEOUT_MRK, 1'b0, 24'd0, 24'd0},     // marker code is a pulse here
    '{8'hFF, 1'b1, 24'd0, 24'd6350},
    '{irpp_pkg::HDR_LO, 1'b0, 24'd0, 24'd0},
    '{irpp_pkg::HDR_HI, 1'b1, 24'd0, 24'd1500},       // header-like pulse
    '{8'h00, 1'b0, 24'd0, 24'd0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic                          cfg_we;
  logic [irpp_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [irpp_pkg::CfgDataW-1:0] cfg_wdata;

  // sideband travelling with each byte: hand-written expectation
  logic                      row_typed;
  logic [irpp_pkg::DurW-1:0] row_space_us;
  logic [irpp_pkg::DurW-1:0] row_pulse_us;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_serial;
  int mismatches;

  // decoder state and register copies
  parse_mode_t                mode;
  logic [4:0]                 bytes_to_go;
  logic [irpp_pkg::DurW-1:0]  space_total;
  logic [irpp_pkg::TickW-1:0] tick_us;
  logic [irpp_pkg::DurW-1:0]  timeout_us;

  pulse_space_t pending_results[$];

  irpp_byte_if  in_ch ();
  irpp_pulse_if out_ch ();

  ir_raw_packet_to_pulse_space dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void decode_byte(input logic [irpp_pkg::ByteW-1:0] b);
    logic [irpp_pkg::DurW-1:0] dur;
    dur = irpp_pkg::DurW'(b[6:0]) * irpp_pkg::DurW'(tick_us);
    case (mode)
      PM_PACKET: begin
        if (b[7]) begin
          pending_results.push_back('{space_total, 1'b0, 1'b0});
          pending_results.push_back('{dur, 1'b1, 1'b1});
          space_total = '0;
        end else begin
          space_total = space_total + dur;
        end
        bytes_to_go = bytes_to_go - 5'd1;
        if (bytes_to_go == 5'd0) mode = PM_IDLE;
      end
      PM_SKIP: begin
        bytes_to_go = bytes_to_go - 5'd1;
        if (bytes_to_go == 5'd0) mode = PM_IDLE;
      end
      default: begin
        mode = PM_IDLE;
        if (b >= irpp_pkg::HDR_LO && b <= irpp_pkg::HDR_HI) begin
          bytes_to_go = b[4:0];
          mode = PM_PACKET;
        end else if (b == irpp_pkg::TIMEOUT_MRK) begin
          space_total = space_total + timeout_us;
          bytes_to_go = irpp_pkg::SKIP_COUNT;
          mode = PM_SKIP;
        end
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [irpp_pkg::DurW-1:0] got,
                               input logic [irpp_pkg::DurW-1:0] want);
    $display("%0t MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // prediction at each transfer, checking of each result
  always @(posedge clk) begin
    int before_n;
    pulse_space_t want;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_idx == irpp_pkg::CFG_TICK_UNIT) tick_us = cfg_wdata[irpp_pkg::TickW-1:0];
        else if (cfg_idx == irpp_pkg::CFG_TIMEOUT_SPACE) timeout_us = cfg_wdata;
      end
      if (in_ch.valid && in_ch.ready) begin
        before_n = pending_results.size();
        decode_byte(in_ch.rx_byte);
        if (row_typed) begin
          if (pending_results.size() != before_n + 2) begin
            flag_mismatch("result count of pulse row",
                          irpp_pkg::DurW'(pending_results.size() - before_n),
                          irpp_pkg::DurW'(2));
          end else begin
            pending_results[before_n].duration     = row_space_us;
            pending_results[before_n + 1].duration = row_pulse_us;
          end
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("unexpected result, duration", out_ch.duration, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.duration !== want.duration)
            flag_mismatch("duration", out_ch.duration, want.duration);
          if (out_ch.is_pulse !== want.is_pulse)
            flag_mismatch("is_pulse", irpp_pkg::DurW'(out_ch.is_pulse),
                          irpp_pkg::DurW'(want.is_pulse));
          if (out_ch.last !== want.last)
            flag_mismatch("last", irpp_pkg::DurW'(out_ch.last), irpp_pkg::DurW'(want.last));
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    int quiet_cycles;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_serial != hold_seen) begin
        hold_seen = hold_serial;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [irpp_pkg::ByteW-1:0] b, input logic typed = 1'b0,
                           input logic [irpp_pkg::DurW-1:0] space_us = '0,
                           input logic [irpp_pkg::DurW-1:0] pulse_us = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.rx_byte <= b;
    row_typed    <= typed;
    row_space_us <= space_us;
    row_pulse_us <= pulse_us;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // wait until every result is in and the pipeline is empty
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [irpp_pkg::TickW-1:0] tick,
                            input logic [irpp_pkg::DurW-1:0] tmo);
    cfg_we    <= 1'b1;
    cfg_idx   <= irpp_pkg::CFG_TICK_UNIT;
    cfg_wdata <= irpp_pkg::CfgDataW'(tick);
    @(posedge clk);
    cfg_idx   <= irpp_pkg::CFG_TIMEOUT_SPACE;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_idling(input int pattern);
    case (pattern)
      0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
      1: begin send_idle_pct = 46; recv_stall_pct <= 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct <= 46; end
      default: begin send_idle_pct = 32; recv_stall_pct <= 32; end
    endcase
  endtask

  function automatic logic [irpp_pkg::ByteW-1:0] data_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'h80;
      3: return 8'hFF;
      default: return irpp_pkg::ByteW'($urandom_range(255));
    endcase
  endfunction

  // mostly well-formed packets, some timeout markers, some stray bytes
  task automatic run_traffic(input int n_items);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(irpp_pkg::HDR_HI[4:0], 1)
                                       : $urandom_range(6, 1);
        send_byte({3'b100, 5'(len)});
        for (int i = 0; i < len; i++) send_byte(data_byte());
        sent += len + 1;
      end else if (pick < 85) begin
        send_byte(irpp_pkg::TIMEOUT_MRK);
        for (int i = 0; i < irpp_pkg::SKIP_COUNT; i++)
          send_byte(irpp_pkg::ByteW'($urandom_range(255)));
        sent += irpp_pkg::SKIP_COUNT + 1;
      end else begin
        send_byte(irpp_pkg::ByteW'($urandom_range(255)));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = irpp_pkg::CFG_TICK_UNIT;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    row_typed     = 1'b0;
    row_space_us  = '0;
    row_pulse_us  = '0;
    hold_serial   = 0;
    mismatches    = 0;
    mode          = PM_IDLE;
    bytes_to_go   = '0;
    space_total   = irpp_pkg::SPACE_ACCUM_RST;
    tick_us       = irpp_pkg::TICK_UNIT_RST;
    timeout_us    = irpp_pkg::TIMEOUT_SPACE_RST;
    set_idling(0);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i])
      send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].space_us, DIRECTED[i].pulse_us);

    for (int p = 0; p < 8; p++) begin
      drain_block();
      case (p)
        0: set_config(8'd1, 24'd0);
        1: set_config(8'd255, 24'hFF_FFFF);
        2: set_config(8'd0, irpp_pkg::DurW'($urandom_range(24'hFF_FFFF)));
        4: set_config(irpp_pkg::TICK_UNIT_RST, irpp_pkg::TIMEOUT_SPACE_RST);
        6: set_config(8'd255, 24'd0);
        7: set_config(8'd1, 24'hFF_FFFF);
        default: set_config(irpp_pkg::TickW'($urandom_range(255, 1)),
                            irpp_pkg::DurW'($urandom_range(24'hFF_FFFF)));
      endcase
      set_idling(p % 4);
      run_traffic(PHASE_ITEMS);
    end

    // receiver holds off while bytes keep coming, so the input backs up
    drain_block();
    set_idling(0);
    hold_serial <= hold_serial + 1;
    run_traffic(100);

    drain_block();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch("results never delivered", irpp_pkg::DurW'(pending_results.size()),
                    '0);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/irpp_pkg.sv
src/irpp_byte_if.sv
src/irpp_pulse_if.sv
src/ir_raw_packet_to_pulse_space.sv
dv/ir_raw_packet_to_pulse_space_tb.sv
